// ===== design/rdq_pkg.sv =====
// shared types and codes for the reversible deque unit
package rdq_pkg;

  // field widths of the stream payloads
  localparam int ACTION_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REVERSE    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // input beat taken: update pointers, write ring
    logic rd_en;   // read both physical ends of the ring
    logic load;    // load the result register
  } dp_cmd_t;

endpackage

// ===== design/reversible_deque_unit.sv =====
// top level of the reversible deque unit
// Double-ended queue of DEPTH signed words held in a ring, with a reverse flag that
// swaps which physical end serves the front and the back. Each input beat carries one
// action and produces exactly one result beat with the logical first and last values
// (zero when empty), the element count and a status. An item passes the accept state,
// which updates pointers and writes the ring, the read state, which reads both physical
// ends from the ring memory's registered read ports, and the load state, which loads the
// result register once the output side can take a new result. A new item is accepted
// again right after that, while the previous result may still wait in the result
// register; the unit takes no new item while one is in work.
// Reset clears pointers, count and the reverse flag at once; no clearing pass is needed.
module reversible_deque_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // action [2:0], push_value [34:3], zero fill [39:35]
  input  logic [rdq_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // first_value [31:0], last_value [63:32], item_count [68:64], status [70:69],
  // zero fill [71]
  output logic [rdq_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import rdq_pkg::*;

  dp_cmd_t                   cmd;
  logic signed [VALUE_W-1:0] first_value;
  logic signed [VALUE_W-1:0] last_value;
  logic [COUNT_W-1:0]        item_count;
  logic [STATUS_W-1:0]       status;

  // control sequencing
  rdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  // queue datapath
  rdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (s_tdata[ACTION_W-1:0]),
    .push_value  (s_tdata[ACTION_W+VALUE_W-1:ACTION_W]),
    .first_value (first_value),
    .last_value  (last_value),
    .item_count  (item_count),
    .status      (status)
  );

  // pack the result beat
  assign m_tdata = {1'b0, status, item_count, last_value, first_value};

endmodule

// ===== design/rdq_ram.sv =====
// generic ram, one write port and two registered read ports
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/rdq_datapath.sv =====
// deque datapath: ring pointers, count, reverse flag, ring memory and result register
module rdq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rdq_pkg::dp_cmd_t                 cmd,
  input  logic [rdq_pkg::ACTION_W-1:0]     action,
  input  logic signed [rdq_pkg::VALUE_W-1:0] push_value,
  output logic signed [rdq_pkg::VALUE_W-1:0] first_value,
  output logic signed [rdq_pkg::VALUE_W-1:0] last_value,
  output logic [rdq_pkg::COUNT_W-1:0]      item_count,
  output logic [rdq_pkg::STATUS_W-1:0]     status
);
  import rdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic [AW-1:0]       start;
  logic [AW-1:0]       start_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                rev;
  logic                rev_next;
  logic [STATUS_W-1:0] acc_status;
  logic [STATUS_W-1:0] acc_status_next;

  logic                is_full;
  logic                is_empty;
  logic                front_op;
  logic                at_head;
  logic [AW-1:0]       start_dec;
  logic [AW-1:0]       start_inc;
  logic [SW-1:0]       put_sum;
  logic [AW-1:0]       put_addr;
  logic [SW-1:0]       tail_sum;
  logic [AW-1:0]       tail_addr;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;
  logic signed [VALUE_W-1:0] head_word;
  logic signed [VALUE_W-1:0] tail_word;

  // occupancy and ring address arithmetic
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign front_op  = (action == ACT_PUSH_FRONT) || (action == ACT_POP_FRONT);
  assign at_head   = front_op ^ rev;
  assign start_dec = (start == '0) ? AW'(DEPTH - 1) : start - 1'b1;
  assign start_inc = (start == AW'(DEPTH - 1)) ? '0 : start + 1'b1;
  assign put_sum   = SW'(start) + SW'(count);
  assign put_addr  = (put_sum >= SW'(DEPTH)) ? AW'(put_sum - SW'(DEPTH)) : AW'(put_sum);
  assign tail_sum  = SW'(start) + SW'(count) - 1'b1;
  assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  // action decode
  always_comb begin
    start_next      = start;
    count_next      = count;
    rev_next        = rev;
    acc_status_next = ST_OK;
    we              = 1'b0;
    waddr           = at_head ? start_dec : put_addr;
    unique case (action) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (is_full) begin
          acc_status_next = ST_PUSH_FULL;
        end else begin
          we         = cmd.accept;
          count_next = count + 1'b1;
          if (at_head) begin
            start_next = start_dec;
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (is_empty) begin
          acc_status_next = ST_POP_EMPTY;
        end else begin
          count_next = count - 1'b1;
          if (at_head) begin
            start_next = start_inc;
          end
        end
      end
      ACT_REVERSE: begin
        rev_next = ~rev;
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start      <= '0;
      count      <= '0;
      rev        <= 1'b0;
      acc_status <= ST_OK;
    end else if (cmd.accept) begin
      start      <= start_next;
      count      <= count_next;
      rev        <= rev_next;
      acc_status <= acc_status_next;
    end
  end

  // ring storage, both physical ends read after the update
  rdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (DATA_WIDTH'(push_value)),
    .re      (cmd.rd_en),
    .raddr_a (start),
    .raddr_b (tail_addr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // sign extend or truncate stored words to the result width
  assign head_word = VALUE_W'(signed'(rdata_a));
  assign tail_word = VALUE_W'(signed'(rdata_b));

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_count <= COUNT_W'(count);
      status     <= acc_status;
      if (is_empty) begin
        first_value <= '0;
        last_value  <= '0;
      end else if (rev) begin
        first_value <= tail_word;
        last_value  <= head_word;
      end else begin
        first_value <= head_word;
        last_value  <= tail_word;
      end
    end
  end

endmodule

// ===== design/rdq_ctrl.sv =====
// deque controller: sequences accept, ring read and result load, owns the output valid
module rdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             m_tready,
  output logic             s_tready,
  output logic             m_tvalid,
  output rdq_pkg::dp_cmd_t cmd
);
  import rdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_full;
  logic       out_free;

  // result register can take a new result
  assign out_free = !out_full || m_tready;
  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_full;

endmodule

// ===== design/rdq_checker.sv =====
// port level checks for the reversible deque unit, bound to the top level
module rdq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rdq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import rdq_pkg::*;

  // one item in work at a time: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[70:69] == ST_OK || m_tdata[70:69] == ST_POP_EMPTY ||
                  m_tdata[70:69] == ST_PUSH_FULL))
    else $error("undefined status code");

  // a pop on an empty queue leaves it empty, so both peeks read zero
  a_pop_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[70:69] == ST_POP_EMPTY) |-> (m_tdata[63:0] == '0))
    else $error("nonzero peek after pop on empty");

  // after an accept with no result waiting, no result appears before the item's own result is loaded
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> (!m_tvalid ##1 !m_tvalid))
    else $error("result appeared too early");

endmodule

bind reversible_deque_unit rdq_checker u_rdq_checker (.*);

// ===== bench/testbench.sv =====
// self-checking stream testbench for the reversible deque unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rdq_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 12;

  // one expected result beat
  typedef struct packed {
    logic [VALUE_W-1:0]  first_value;
    logic [VALUE_W-1:0]  last_value;
    logic [COUNT_W-1:0]  item_count;
    logic [STATUS_W-1:0] status;
  } deque_view_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // action [2:0], push_value [34:3], zero fill [39:35]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // first_value [31:0], last_value [63:32], item_count [68:64], status [70:69],
  // zero fill [71]
  logic [OUT_TDATA_W-1:0] m_tdata;

  // mirror of the deque state
  logic [VALUE_W-1:0] mirror_ring [RING_DEPTH];
  logic [3:0]         mirror_start;
  logic [COUNT_W-1:0] mirror_count;
  logic               mirror_reversed;

  deque_view_t pending_views [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  reversible_deque_unit #(
    .DEPTH      (RING_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL reversible_deque_unit");
      $finish;
    end
  end

  // apply one action to the mirror and return the view it leaves
  function automatic deque_view_t apply_deque_action(input logic [ACTION_W-1:0] act,
                                                     input logic [VALUE_W-1:0] val);
    deque_view_t view;
    logic        at_head;
    logic [3:0]  tail_idx;
    view.status = ST_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (mirror_count == COUNT_W'(RING_DEPTH)) begin
          view.status = ST_PUSH_FULL;
        end else begin
          at_head = (act == ACT_PUSH_FRONT) ^ mirror_reversed;
          if (at_head) begin
            mirror_start = mirror_start - 4'd1;
            mirror_ring[mirror_start] = val;
          end else begin
            mirror_ring[mirror_start + mirror_count[3:0]] = val;
          end
          mirror_count = mirror_count + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (mirror_count == '0) begin
          view.status = ST_POP_EMPTY;
        end else begin
          at_head = (act == ACT_POP_FRONT) ^ mirror_reversed;
          if (at_head) mirror_start = mirror_start + 4'd1;
          mirror_count = mirror_count - 1'b1;
        end
      end
      ACT_REVERSE: mirror_reversed = ~mirror_reversed;
      default: ;
    endcase
    // logical ends after the step
    tail_idx = mirror_start + mirror_count[3:0] - 4'd1;
    if (mirror_count == '0) begin
      view.first_value = '0;
      view.last_value  = '0;
    end else if (mirror_reversed) begin
      view.first_value = mirror_ring[tail_idx];
      view.last_value  = mirror_ring[mirror_start];
    end else begin
      view.first_value = mirror_ring[mirror_start];
      view.last_value  = mirror_ring[tail_idx];
    end
    view.item_count = mirror_count;
    return view;
  endfunction

  // send one beat, with random idle cycles before it
  task automatic issue_action(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - ACTION_W - VALUE_W){1'b0}}, val, act};
    do @(posedge clk); while (!s_tready);
    pending_views = {pending_views, apply_deque_action(act, val)};
  endtask

  // compare one result beat with the oldest expectation
  task automatic compare_view(input logic [OUT_TDATA_W-1:0] beat);
    deque_view_t got;
    deque_view_t want;
    got.first_value = beat[VALUE_W-1:0];
    got.last_value  = beat[2*VALUE_W-1:VALUE_W];
    got.item_count  = beat[2*VALUE_W+COUNT_W-1:2*VALUE_W];
    got.status      = beat[2*VALUE_W+COUNT_W+STATUS_W-1 -: STATUS_W];
    if (pending_views.size() == 0) begin
      $error("result beat with no expected result: %h", beat);
      mismatches++;
    end else begin
      want = pending_views.pop_front();
      if (got.first_value !== want.first_value) begin
        $error("first_value expected %0d got %0d",
               $signed(want.first_value), $signed(got.first_value));
        mismatches++;
      end
      if (got.last_value !== want.last_value) begin
        $error("last_value expected %0d got %0d",
               $signed(want.last_value), $signed(got.last_value));
        mismatches++;
      end
      if (got.item_count !== want.item_count) begin
        $error("item_count expected %0d got %0d", want.item_count, got.item_count);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        mismatches++;
      end
    end
  endtask

  // result side: check taken beats, drive ready with random stalls and long holds
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) compare_view(m_tdata);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // random word, now and then an extreme
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // empty ring: peeks read zero, pops flagged, spare codes act as query
  task automatic test_empty_ring();
    issue_action(ACT_QUERY, 32'h1234_5678);
    issue_action(ACT_POP_FRONT, 32'hffff_ffff);
    issue_action(ACT_POP_BACK, 32'h0);
    issue_action(3'd6, 32'hdead_beef);
    issue_action(3'd7, 32'h5555_aaaa);
    issue_action(ACT_REVERSE, 32'h0);
    issue_action(ACT_POP_FRONT, 32'h0);
    issue_action(ACT_REVERSE, 32'h0);
  endtask

  // extreme words pushed at both ends, then a query
  task automatic test_extreme_values();
    issue_action(ACT_PUSH_FRONT, 32'h7fff_ffff);
    issue_action(ACT_PUSH_BACK, 32'h8000_0000);
    issue_action(ACT_PUSH_FRONT, 32'hffff_ffff);
    issue_action(ACT_PUSH_BACK, 32'h0000_0000);
    issue_action(ACT_QUERY, 32'h0);
  endtask

  // reversal swaps which physical end serves each logical end
  task automatic test_reversal_ends();
    issue_action(ACT_REVERSE, 32'h0);
    issue_action(ACT_PUSH_FRONT, 32'h0000_0001);
    issue_action(ACT_PUSH_BACK, 32'hffff_fffe);
    issue_action(ACT_POP_BACK, 32'h0);
    issue_action(ACT_POP_FRONT, 32'h0);
    issue_action(ACT_REVERSE, 32'h0);
    issue_action(ACT_POP_BACK, 32'h0);
    issue_action(ACT_POP_FRONT, 32'h0);
  endtask

  // fill to full, push on full both ways, then drain past empty
  task automatic test_fill_and_drain();
    while (mirror_count < COUNT_W'(RING_DEPTH))
      issue_action($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_value());
    issue_action(ACT_PUSH_FRONT, pick_value());
    issue_action(ACT_PUSH_BACK, pick_value());
    issue_action(ACT_REVERSE, 32'h0);
    issue_action(ACT_PUSH_FRONT, pick_value());
    while (mirror_count != '0)
      issue_action($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK, 32'h0);
    issue_action(ACT_POP_BACK, 32'h0);
    issue_action(ACT_REVERSE, 32'h0);
  endtask

  // runs that lean toward filling, draining, mixing or reversing, so full and empty recur
  task automatic test_random_traffic(input int item_total);
    int                  sent;
    int                  run_kind;
    int                  run_len;
    int                  roll;
    logic [ACTION_W-1:0] act;
    sent = 0;
    while (sent < item_total) begin
      run_kind = $urandom_range(3);
      run_len  = $urandom_range(1, 24);
      for (int i = 0; i < run_len && sent < item_total; i++) begin
        roll = $urandom_range(99);
        case (run_kind)
          0: act = (roll < 80) ? ($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK)
                               : ACTION_W'($urandom_range(7));
          1: act = (roll < 80) ? ($urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK)
                               : ACTION_W'($urandom_range(7));
          2: act = (roll < 5) ? ACTION_W'($urandom_range(6, 7))
                              : ACTION_W'($urandom_range(5));
          default: act = (roll < 30) ? ACT_REVERSE : ACTION_W'($urandom_range(3));
        endcase
        issue_action(act, pick_value());
        sent++;
      end
    end
  endtask

  // long receiver hold while the sender keeps offering beats
  task automatic test_output_backpressure();
    hold_request = 200;
    for (int i = 0; i < 40; i++)
      issue_action(ACTION_W'($urandom_range(5)), pick_value());
  endtask

  // stimulus sequence
  initial begin
    mirror_start    = '0;
    mirror_count    = '0;
    mirror_reversed = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_ring();
    test_extreme_values();
    test_reversal_ends();
    test_fill_and_drain();

    send_idle_pct = 21;
    recv_idle_pct = 83;
    test_random_traffic(370);
    send_idle_pct = 83;
    recv_idle_pct = 21;
    test_random_traffic(370);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(330);
    test_output_backpressure();
    s_tvalid <= 1'b0;

    // let the last results come out
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS reversible_deque_unit");
    end else begin
      $display("FAIL reversible_deque_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rdq_pkg.sv
design/rdq_ram.sv
design/rdq_datapath.sv
design/rdq_ctrl.sv
design/reversible_deque_unit.sv
design/rdq_checker.sv
bench/testbench.sv
